// ----- design/serial_frame_receiver_macros.svh -----
// assertion macros of the serial frame receiver, used by sfr_core
// expects clk_i and rst_ni in the scope of each use
`ifndef SERIAL_FRAME_RECEIVER_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define SFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sfr_pkg.sv -----
// types and constants of the serial frame receiver
// no dependencies
package sfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned NumW    = 32;
  localparam int unsigned TickW   = 32;
  localparam int unsigned StatW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned OutDatW = 64;
  localparam int unsigned NumBytes = 4;
  localparam int unsigned MinLen   = 5;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SECOND = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_BODY   = 3'd4,
    PH_STOP   = 3'd5
  } phase_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CHECKSUM = 3'd2,
    ST_RESYNC   = 3'd3,
    ST_NO_STOP  = 3'd4,
    ST_TIMEOUT  = 3'd5
  } status_e;

  typedef enum logic {
    KIND_BODY   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_FIRST  = 2'd0,
    CFG_START_SECOND = 2'd1,
    CFG_STOP         = 2'd2,
    CFG_TIMEOUT      = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [ByteW-1:0] start_first;
    logic [ByteW-1:0] start_second;
    logic [ByteW-1:0] stop_byte;
    logic [TickW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] body_byte;
    status_e          status;
    logic [NumW-1:0]  packet_number;
    logic [LenW-1:0]  body_length;
  } result_t;

endpackage

// ----- design/serial_frame_receiver.sv -----
// serial frame receiver top level: input register, deframing core, output register
// a result reaches the master side through the input register and then the output register
// throughput: one beat per cycle while the master side takes results, set by the core's state update on each step
// one beat can be taken into the input register while a result waits, the output register parts the two sides
// reset: asynchronous active low, returns to hunting with config at default values
// depends on sfr_pkg, sfr_cfg_regs and sfr_core
module serial_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // rx_byte
  input  logic                        s_axis_tuser_i,  // req_type
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // body_byte, frame_status, packet_number, body_length, zero pad
  output logic [sfr_pkg::OutDatW-1:0] m_axis_tdata_o,
  output logic                        m_axis_tuser_o,  // result_kind
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfr_pkg::CfgDatW-1:0] cfg_data_i
);

  sfr_pkg::cfg_t    cfg;
  logic             in_valid_q;
  logic             in_tick_q;
  logic [7:0]       in_byte_q;
  logic             advance;
  logic             res_valid;
  sfr_pkg::result_t res;
  logic             out_valid_q, out_valid_d;
  sfr_pkg::result_t out_q;

  assign cfg_ready_o = 1'b1;

  sfr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_tick_q <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  sfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .tick_i      (in_tick_q),
    .rx_byte_i   (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance)              out_valid_d = res_valid;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {5'd0, out_q.body_length, out_q.packet_number,
                            out_q.status, out_q.body_byte};

endmodule

// ----- design/sfr_cfg_regs.sv -----
// configuration registers of the serial frame receiver
// depends on sfr_pkg
module sfr_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [sfr_pkg::CfgIdxW-1:0] wr_index_i,
  input  logic [sfr_pkg::CfgDatW-1:0] wr_data_i,
  output sfr_pkg::cfg_t               cfg_o
);

  sfr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (sfr_pkg::cfg_index_e'(wr_index_i))
        sfr_pkg::CFG_START_FIRST:  cfg_d.start_first   = wr_data_i[sfr_pkg::ByteW-1:0];
        sfr_pkg::CFG_START_SECOND: cfg_d.start_second  = wr_data_i[sfr_pkg::ByteW-1:0];
        sfr_pkg::CFG_STOP:         cfg_d.stop_byte     = wr_data_i[sfr_pkg::ByteW-1:0];
        sfr_pkg::CFG_TIMEOUT:      cfg_d.timeout_ticks = wr_data_i[sfr_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first   <= 8'd18;
      cfg_q.start_second  <= 8'd19;
      cfg_q.stop_byte     <= 8'd10;
      cfg_q.timeout_ticks <= 32'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/sfr_core.sv -----
// frame state and per-beat deframing logic of the serial frame receiver
// depends on sfr_pkg and serial_frame_receiver_macros.svh
`include "serial_frame_receiver_macros.svh"

module sfr_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      tick_i,
  input  logic [sfr_pkg::ByteW-1:0] rx_byte_i,
  input  sfr_pkg::cfg_t             cfg_i,
  output logic                      res_valid_o,
  output sfr_pkg::result_t          res_o
);

  sfr_pkg::phase_e phase_q, phase_d;
  logic [sfr_pkg::LenW-1:0]  len_q, len_d;
  logic [sfr_pkg::LenW-1:0]  count_q, count_d;
  logic [sfr_pkg::ByteW-1:0] sum_q, sum_d;
  logic [sfr_pkg::ByteW-1:0] chk_q [2];
  logic [sfr_pkg::ByteW-1:0] chk_d [2];
  logic [sfr_pkg::NumW-1:0]  num_q, num_d;
  logic [sfr_pkg::NumW-1:0]  expect_q, expect_d;
  logic [sfr_pkg::TickW-1:0] elapsed_q, elapsed_d;

  logic [sfr_pkg::TickW-1:0] elapsed_inc;
  logic                      timed_out;
  logic                      in_frame;
  logic [sfr_pkg::LenW:0]    pos_ext;
  logic                      sum_region;
  logic                      last_body;
  logic [sfr_pkg::LenW-1:0]  len_lo_val;
  logic [4:0]                hex_hi, hex_lo;
  logic                      chk_ok;

  // bit 4 flags a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    else                               v = 5'h10;
    return v;
  endfunction

  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign timed_out   = elapsed_inc > cfg_i.timeout_ticks;
  assign in_frame    = (phase_q == sfr_pkg::PH_LEN_HI) || (phase_q == sfr_pkg::PH_LEN_LO) ||
                       (phase_q == sfr_pkg::PH_BODY) || (phase_q == sfr_pkg::PH_STOP);
  assign pos_ext     = {1'b0, count_q};
  assign sum_region  = (pos_ext + 17'd2) < {1'b0, len_q};
  assign last_body   = (pos_ext + 17'd1) >= {1'b0, len_q};
  assign len_lo_val  = {len_q[15:8], rx_byte_i};
  assign hex_hi      = hex_value(chk_q[0]);
  assign hex_lo      = hex_value(chk_q[1]);
  assign chk_ok      = !hex_hi[4] && !hex_lo[4] && ({hex_hi[3:0], hex_lo[3:0]} == sum_q);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (tick_i) begin
      if (in_frame && timed_out) phase_d = sfr_pkg::PH_IDLE;
    end else begin
      unique case (phase_q)
        sfr_pkg::PH_IDLE:
          phase_d = (rx_byte_i == cfg_i.start_first) ? sfr_pkg::PH_SECOND : sfr_pkg::PH_IDLE;
        sfr_pkg::PH_SECOND:
          phase_d = (rx_byte_i == cfg_i.start_second) ? sfr_pkg::PH_LEN_HI : sfr_pkg::PH_IDLE;
        sfr_pkg::PH_LEN_HI: phase_d = sfr_pkg::PH_LEN_LO;
        sfr_pkg::PH_LEN_LO:
          phase_d = (len_lo_val == '0) ? sfr_pkg::PH_STOP : sfr_pkg::PH_BODY;
        sfr_pkg::PH_BODY:
          if (last_body) phase_d = sfr_pkg::PH_STOP;
        sfr_pkg::PH_STOP: phase_d = sfr_pkg::PH_IDLE;
        default: phase_d = sfr_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    len_d       = len_q;
    count_d     = count_q;
    sum_d       = sum_q;
    chk_d       = chk_q;
    num_d       = num_q;
    expect_d    = expect_q;
    elapsed_d   = elapsed_q;
    res_valid_o = 1'b0;
    res_o.kind      = sfr_pkg::KIND_STATUS;
    res_o.body_byte = '0;
    res_o.status    = sfr_pkg::ST_OK;
    if (tick_i) begin
      if (in_frame) begin
        elapsed_d = elapsed_inc;
        if (timed_out) begin
          res_valid_o  = 1'b1;
          res_o.status = sfr_pkg::ST_TIMEOUT;
        end
      end
    end else begin
      unique case (phase_q)
        sfr_pkg::PH_SECOND:
          if (rx_byte_i == cfg_i.start_second) begin
            len_d     = '0;
            count_d   = '0;
            sum_d     = '0;
            chk_d[0]  = '0;
            chk_d[1]  = '0;
            num_d     = '0;
            elapsed_d = '0;
          end
        sfr_pkg::PH_LEN_HI: len_d = {rx_byte_i, 8'h00};
        sfr_pkg::PH_LEN_LO: len_d = len_lo_val;
        sfr_pkg::PH_BODY: begin
          if (count_q < 16'(sfr_pkg::NumBytes)) num_d = {num_q[23:0], rx_byte_i};
          if (sum_region) sum_d = sum_q + rx_byte_i;
          else            chk_d[count_q[0] ^ len_q[0]] = rx_byte_i;
          count_d = count_q + 1'b1;
          if (sum_region && (count_q >= 16'(sfr_pkg::NumBytes))) begin
            res_valid_o     = 1'b1;
            res_o.kind      = sfr_pkg::KIND_BODY;
            res_o.body_byte = rx_byte_i;
          end
        end
        sfr_pkg::PH_STOP: begin
          res_valid_o = 1'b1;
          if (rx_byte_i != cfg_i.stop_byte) begin
            res_o.status = sfr_pkg::ST_NO_STOP;
          end else if (len_q < 16'(sfr_pkg::MinLen)) begin
            res_o.status = sfr_pkg::ST_SHORT;
            expect_d     = expect_q + 1'b1;
          end else if (!chk_ok) begin
            res_o.status = sfr_pkg::ST_CHECKSUM;
            expect_d     = expect_q + 1'b1;
          end else if (num_q != expect_q) begin
            res_o.status = sfr_pkg::ST_RESYNC;
            expect_d     = num_q + 1'b1;
          end else begin
            res_o.status = sfr_pkg::ST_OK;
            expect_d     = expect_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    res_o.packet_number = num_d;
    res_o.body_length   = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sfr_pkg::PH_IDLE;
      len_q     <= '0;
      count_q   <= '0;
      sum_q     <= '0;
      chk_q[0]  <= '0;
      chk_q[1]  <= '0;
      num_q     <= '0;
      expect_q  <= '0;
      elapsed_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      chk_q     <= chk_d;
      num_q     <= num_d;
      expect_q  <= expect_d;
      elapsed_q <= elapsed_d;
    end
  end

  `SFR_ASSERT_SAME(a_body_only_in_body, res_valid_o && res_o.kind == sfr_pkg::KIND_BODY, phase_q == sfr_pkg::PH_BODY && res_o.status == sfr_pkg::ST_OK, "body beat outside body phase")
  `SFR_ASSERT_NEXT(a_status_ends_frame, step_i && res_valid_o && res_o.kind == sfr_pkg::KIND_STATUS, phase_q == sfr_pkg::PH_IDLE, "frame status without return to idle")
  `SFR_ASSERT_NEXT(a_hunt_progress, step_i && !tick_i && phase_q == sfr_pkg::PH_IDLE, phase_q == sfr_pkg::PH_IDLE || phase_q == sfr_pkg::PH_SECOND, "idle left to a wrong phase")

endmodule

// ----- tb/serial_frame_receiver_test.sv -----
// testbench for serial_frame_receiver: drives framed byte and tick beats,
// predicts every body byte and frame status and checks the master side beat by beat
// depends on sfr_pkg and the serial_frame_receiver rtl
module serial_frame_receiver_test;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 6;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_NOT_HEX, FLAW_NO_STOP} flaw_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [7:0]                  s_tdata;
  logic                        s_tuser;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [sfr_pkg::OutDatW-1:0] m_tdata;
  logic                        m_tuser;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [sfr_pkg::CfgIdxW-1:0] cfg_index;
  logic [sfr_pkg::CfgDatW-1:0] cfg_data;

  // register copy and deframing state of the prediction
  sfr_pkg::cfg_t             regs;
  sfr_pkg::phase_e           ph;
  logic [sfr_pkg::LenW-1:0]  len_field;
  logic [sfr_pkg::LenW-1:0]  body_pos;
  logic [7:0]                body_sum;
  logic [7:0]                sum_chars [2];
  logic [sfr_pkg::NumW-1:0]  number_acc;
  logic [sfr_pkg::NumW-1:0]  next_count;
  logic [sfr_pkg::TickW-1:0] tick_count;

  sfr_pkg::result_t pending_results [$];
  logic [7:0]       body_q [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned busy_beats = 0;
  int unsigned hold_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned tick_pct = 0;

  serial_frame_receiver i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    sfr_pkg::result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result_kind: expected no result, got %0d", m_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
          mismatches++;
        end
        if (m_tdata[sfr_pkg::ByteW-1:0] !== want.body_byte) begin
          $error("body_byte: expected %0h, got %0h", want.body_byte,
                 m_tdata[sfr_pkg::ByteW-1:0]);
          mismatches++;
        end
        if (m_tdata[sfr_pkg::ByteW +: sfr_pkg::StatW] !== want.status) begin
          $error("frame_status: expected %0d, got %0d", want.status,
                 m_tdata[sfr_pkg::ByteW +: sfr_pkg::StatW]);
          mismatches++;
        end
        if (m_tdata[sfr_pkg::ByteW+sfr_pkg::StatW +: sfr_pkg::NumW] !== want.packet_number) begin
          $error("packet_number: expected %0h, got %0h", want.packet_number,
                 m_tdata[sfr_pkg::ByteW+sfr_pkg::StatW +: sfr_pkg::NumW]);
          mismatches++;
        end
        if (m_tdata[sfr_pkg::ByteW+sfr_pkg::StatW+sfr_pkg::NumW +: sfr_pkg::LenW]
            !== want.body_length) begin
          $error("body_length: expected %0d, got %0d", want.body_length,
                 m_tdata[sfr_pkg::ByteW+sfr_pkg::StatW+sfr_pkg::NumW +: sfr_pkg::LenW]);
          mismatches++;
        end
      end
    end
  end

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h57);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nibble, input bit upper);
    if (nibble < 4'd10) return 8'h30 + 8'(nibble);
    return (upper ? 8'h37 : 8'h57) + 8'(nibble);
  endfunction

  function automatic sfr_pkg::result_t make_result(input sfr_pkg::kind_e k,
                                                   input logic [7:0] b,
                                                   input sfr_pkg::status_e st);
    sfr_pkg::result_t r;
    r.kind          = k;
    r.body_byte     = b;
    r.status        = st;
    r.packet_number = number_acc;
    r.body_length   = len_field;
    return r;
  endfunction

  function automatic void clear_deframer();
    regs = '{start_first: 8'd18, start_second: 8'd19, stop_byte: 8'd10,
             timeout_ticks: 32'd1000};
    ph         = sfr_pkg::PH_IDLE;
    len_field  = '0;
    body_pos   = '0;
    body_sum   = '0;
    sum_chars  = '{8'h00, 8'h00};
    number_acc = '0;
    next_count = '0;
    tick_count = '0;
  endfunction

  // advances the deframing state by one beat, returns 1 when a result is due
  function automatic bit deframe(input sfr_pkg::req_e req, input logic [7:0] b,
                                 output sfr_pkg::result_t res);
    logic [31:0]       pos;
    sfr_pkg::status_e  st;
    int                hi;
    int                lo;
    res = '0;
    if (req == sfr_pkg::REQ_TICK) begin
      if (ph < sfr_pkg::PH_LEN_HI || ph > sfr_pkg::PH_STOP) return 1'b0;
      if (tick_count != '1) tick_count++;
      if (tick_count > regs.timeout_ticks) begin
        ph  = sfr_pkg::PH_IDLE;
        res = make_result(sfr_pkg::KIND_STATUS, 8'h00, sfr_pkg::ST_TIMEOUT);
        return 1'b1;
      end
      return 1'b0;
    end
    case (ph)
      sfr_pkg::PH_SECOND: begin
        if (b == regs.start_second) begin
          ph         = sfr_pkg::PH_LEN_HI;
          len_field  = '0;
          body_pos   = '0;
          body_sum   = '0;
          sum_chars  = '{8'h00, 8'h00};
          number_acc = '0;
          tick_count = '0;
        end else begin
          ph = sfr_pkg::PH_IDLE;
        end
      end
      sfr_pkg::PH_LEN_HI: begin
        len_field = {b, 8'h00};
        ph        = sfr_pkg::PH_LEN_LO;
      end
      sfr_pkg::PH_LEN_LO: begin
        len_field = {len_field[15:8], b};
        ph        = (len_field == '0) ? sfr_pkg::PH_STOP : sfr_pkg::PH_BODY;
      end
      sfr_pkg::PH_BODY: begin
        pos = 32'(body_pos);
        if (pos < sfr_pkg::NumBytes) number_acc = {number_acc[sfr_pkg::NumW-9:0], b};
        if (pos + 2 < 32'(len_field)) body_sum = body_sum + b;
        else sum_chars[pos[0] ^ len_field[0]] = b;
        body_pos = body_pos + 1'b1;
        if (pos + 1 >= 32'(len_field)) ph = sfr_pkg::PH_STOP;
        if (pos >= sfr_pkg::NumBytes && pos + 2 < 32'(len_field)) begin
          res = make_result(sfr_pkg::KIND_BODY, b, sfr_pkg::ST_OK);
          return 1'b1;
        end
      end
      sfr_pkg::PH_STOP: begin
        hi = hex_nibble(sum_chars[0]);
        lo = hex_nibble(sum_chars[1]);
        if (b != regs.stop_byte) begin
          st = sfr_pkg::ST_NO_STOP;
        end else if (len_field < sfr_pkg::MinLen) begin
          st = sfr_pkg::ST_SHORT;
          next_count++;
        end else if (hi < 0 || lo < 0 || hi * 16 + lo != int'(body_sum)) begin
          st = sfr_pkg::ST_CHECKSUM;
          next_count++;
        end else if (number_acc != next_count) begin
          st = sfr_pkg::ST_RESYNC;
          next_count = number_acc + 1;
        end else begin
          st = sfr_pkg::ST_OK;
          next_count++;
        end
        ph  = sfr_pkg::PH_IDLE;
        res = make_result(sfr_pkg::KIND_STATUS, 8'h00, st);
        return 1'b1;
      end
      default: begin
        ph = (b == regs.start_first) ? sfr_pkg::PH_SECOND : sfr_pkg::PH_IDLE;
      end
    endcase
    return 1'b0;
  endfunction

  // returns at the rising edge that accepted the beat, tvalid still high
  task automatic send_beat(input sfr_pkg::req_e req, input logic [7:0] b);
    sfr_pkg::result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= req;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (ph >= sfr_pkg::PH_LEN_HI ||
        (req == sfr_pkg::REQ_BYTE && (ph == sfr_pkg::PH_SECOND || b == regs.start_first)))
      busy_beats++;
    if (deframe(req, b, res)) pending_results.push_back(res);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_register(input sfr_pkg::cfg_index_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      sfr_pkg::CFG_START_FIRST:  regs.start_first   = value[7:0];
      sfr_pkg::CFG_START_SECOND: regs.start_second  = value[7:0];
      sfr_pkg::CFG_STOP:         regs.stop_byte     = value[7:0];
      sfr_pkg::CFG_TIMEOUT:      regs.timeout_ticks = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // sends start bytes, length field, body_q with random tick beats between its bytes, and the closing byte
  task automatic send_frame(input logic [15:0] len, input logic [7:0] stop);
    send_beat(sfr_pkg::REQ_BYTE, regs.start_first);
    send_beat(sfr_pkg::REQ_BYTE, regs.start_second);
    send_beat(sfr_pkg::REQ_BYTE, len[15:8]);
    send_beat(sfr_pkg::REQ_BYTE, len[7:0]);
    foreach (body_q[i]) begin
      if ($urandom_range(99) < tick_pct) send_beat(sfr_pkg::REQ_TICK, 8'($urandom));
      send_beat(sfr_pkg::REQ_BYTE, body_q[i]);
    end
    send_beat(sfr_pkg::REQ_BYTE, stop);
  endtask

  task automatic send_packet(input logic [31:0] number, input int unsigned payload,
                             input flaw_e flaw);
    logic [7:0] sum;
    logic [7:0] c_hi;
    logic [7:0] c_lo;
    logic [7:0] stop;
    sum = 8'h00;
    body_q.delete();
    for (int i = 3; i >= 0; i--) body_q.push_back(number[8*i +: 8]);
    repeat (payload) body_q.push_back(8'($urandom));
    foreach (body_q[i]) sum = sum + body_q[i];
    if (flaw == FLAW_SUM) sum = sum ^ 8'(1 << $urandom_range(7));
    c_hi = hex_char(sum[7:4], 1'($urandom_range(1)));
    c_lo = hex_char(sum[3:0], 1'($urandom_range(1)));
    if (flaw == FLAW_NOT_HEX) begin
      do c_lo = 8'($urandom); while (hex_nibble(c_lo) >= 0);
      if ($urandom_range(1)) {c_hi, c_lo} = {c_lo, c_hi};
    end
    body_q.push_back(c_hi);
    body_q.push_back(c_lo);
    stop = regs.stop_byte;
    if (flaw == FLAW_NO_STOP) stop = stop ^ 8'($urandom_range(1, 255));
    send_frame(16'(body_q.size()), stop);
  endtask

  task automatic test_directed();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    tick_pct       = 0;
    // hunting: stray bytes, ticks, a broken start pair
    send_beat(sfr_pkg::REQ_BYTE, 8'h00);
    send_beat(sfr_pkg::REQ_BYTE, 8'hFF);
    send_beat(sfr_pkg::REQ_TICK, 8'hA5);
    send_beat(sfr_pkg::REQ_BYTE, regs.start_first);
    send_beat(sfr_pkg::REQ_BYTE, 8'h55);
    send_beat(sfr_pkg::REQ_BYTE, regs.start_first);
    send_beat(sfr_pkg::REQ_TICK, 8'h00);
    send_beat(sfr_pkg::REQ_BYTE, regs.start_first);
    send_packet(next_count, 3, FLAW_NONE);
    body_q.delete();
    send_frame(16'd0, regs.stop_byte);
    repeat (4) body_q.push_back(8'($urandom));
    send_frame(16'd4, regs.stop_byte);
    body_q.delete();
    repeat (5) body_q.push_back(8'($urandom));
    send_frame(16'd5, regs.stop_byte);
    send_packet(next_count, 0, FLAW_SUM);
    send_packet(next_count, 1, FLAW_NOT_HEX);
    send_packet(32'hFFFF_FFFF, 2, FLAW_NONE);
    send_packet(next_count, 1, FLAW_NONE);
    send_packet(next_count, 2, FLAW_NO_STOP);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    set_register(sfr_pkg::CFG_START_FIRST, 32'h00);
    set_register(sfr_pkg::CFG_START_SECOND, 32'hFF);
    set_register(sfr_pkg::CFG_STOP, 32'hFF);
    set_register(sfr_pkg::CFG_TIMEOUT, 32'd1);
    send_packet(next_count, 2, FLAW_NONE);
    // longest length field, ended by the timeout
    send_beat(sfr_pkg::REQ_BYTE, regs.start_first);
    send_beat(sfr_pkg::REQ_BYTE, regs.start_second);
    send_beat(sfr_pkg::REQ_BYTE, 8'hFF);
    send_beat(sfr_pkg::REQ_BYTE, 8'hFF);
    send_beat(sfr_pkg::REQ_BYTE, 8'h00);
    send_beat(sfr_pkg::REQ_TICK, 8'h00);
    send_beat(sfr_pkg::REQ_TICK, 8'hFF);
    wait_drained();
    set_register(sfr_pkg::CFG_START_FIRST, 32'hFF);
    set_register(sfr_pkg::CFG_START_SECOND, 32'h00);
    set_register(sfr_pkg::CFG_STOP, 32'h00);
    set_register(sfr_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
    tick_pct = 30;
    repeat (3) send_packet(next_count, $urandom_range(6), FLAW_NONE);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned gap, input int unsigned stall,
                             input int unsigned beats);
    int unsigned target;
    int unsigned pick;
    flaw_e       flaw;
    wait_drained();
    set_register(sfr_pkg::CFG_START_FIRST, $urandom_range(255));
    set_register(sfr_pkg::CFG_START_SECOND, $urandom_range(255));
    set_register(sfr_pkg::CFG_STOP, $urandom_range(255));
    set_register(sfr_pkg::CFG_TIMEOUT,
                 ($urandom_range(2) == 0) ? 32'd1000 : $urandom_range(1, 60));
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    tick_pct       = 6;
    target         = busy_beats + beats;
    while (busy_beats < target) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        case ($urandom_range(11))
          0:       flaw = FLAW_SUM;
          1:       flaw = FLAW_NOT_HEX;
          2:       flaw = FLAW_NO_STOP;
          default: flaw = FLAW_NONE;
        endcase
        send_packet(($urandom_range(7) == 0) ? 32'($urandom) : next_count,
                    $urandom_range(12), flaw);
      end else if (pick < 86) begin
        body_q.delete();
        repeat ($urandom_range(8)) body_q.push_back(8'($urandom));
        send_frame(16'($urandom_range(12)),
                   $urandom_range(1) ? regs.stop_byte : 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_beat(sfr_pkg::req_e'($urandom_range(1)), 8'($urandom));
      end
    end
  endtask

  task automatic test_output_stall();
    wait_drained();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    tick_pct       = 0;
    hold_cycles    = 400;
    repeat (6) send_packet(next_count, 12, FLAW_NONE);
    wait_drained();
    repeat (3) send_packet(next_count, $urandom_range(12), FLAW_NONE);
  endtask

  initial begin
    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = 8'h00;
    s_tuser   = sfr_pkg::REQ_BYTE;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = sfr_pkg::CFG_START_FIRST;
    cfg_data  = '0;
    clear_deframer();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_register_extremes();
    test_random(0, 0, 250);
    test_random(63, 0, 250);
    test_random(0, 63, 250);
    test_random(16, 16, 250);
    test_output_stall();
    wait_drained();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
